FILE: hw/rtl/hss_pkg.sv
// Shared constants and types for the heat stencil sweep block.
`default_nettype none
package hss_pkg;

	localparam int ACC_BITS  = 48;	// heat sum width
	localparam int CFG_BITS  = 9;	// size field of a config register
	localparam int OUT_DEPTH = 4;	// result queue entries
	localparam int OCC_W     = 3;	// holds 0..OUT_DEPTH

	typedef enum logic {
		REG_COLS = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hss_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
`default_nettype none
module hss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 258
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/hss_out_fifo.sv
// Small result queue between the stencil pipeline and the result channel.
`default_nettype none
module hss_out_fifo #(
	parameter int WIDTH = 81
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [WIDTH-1:0]          push_data,
	input  wire logic                      pop,
	output logic                           valid,
	output logic      [WIDTH-1:0]          data,
	output logic      [hss_pkg::OCC_W-1:0] count
);
	import hss_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);

	logic [WIDTH-1:0] mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] cnt_q;
	logic             do_pop;

	assign do_pop = pop & valid;
	assign valid  = cnt_q != '0;
	assign data   = mem_q[rd_ptr_q];
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + OCC_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - OCC_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/heat_stencil_sweep.sv
// Top level: five-point Jacobi heat stencil over a streamed grid with halo.
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+----------------------------------
//   config   | psel/penable/pwrite/pready | paddr, pwdata -> prdata
//   cell     | cell_valid / cell_ready    | cell_value
//   result   | result_valid/result_ready  | new_value, heat_sum, last
//
// One cell beat per cycle while cell_ready is high. A result passes through
// the prefetched line-store read, sum stage, shift/add stage and result queue.
// The line stores have no reset and no clearing pass; rows 0 and 1 of every
// sweep fill them before they are read. The four-entry result queue sets the
// stall behavior: cell_ready drops once four results are in flight unread.
`default_nettype none
module heat_stencil_sweep #(
	parameter int MAX_COLS   = 256,
	parameter int MAX_ROWS   = 256,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic        [2:0]                   paddr,
	input  wire logic        [31:0]                  pwdata,
	output logic             [31:0]                  prdata,
	output logic                                     pready,
	input  wire logic                                cell_valid,
	output logic                                     cell_ready,
	input  wire logic signed [VALUE_BITS-1:0]        cell_value,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic signed      [VALUE_BITS-1:0]        new_value,
	output logic signed      [hss_pkg::ACC_BITS-1:0] heat_sum,
	output logic                                     last
);
	import hss_pkg::*;

	localparam int DEPTH    = MAX_COLS + 2;
	localparam int COL_W    = $clog2(MAX_COLS + 2);
	localparam int ROW_W    = $clog2(MAX_ROWS + 2);
	localparam int SUM_W    = VALUE_BITS + 2;
	localparam int RES_W    = VALUE_BITS + ACC_BITS + 1;
	localparam int COLS_RST = (MAX_COLS < 256) ? MAX_COLS : 256;
	localparam int ROWS_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;

	// configuration
	logic                cfg_wr;
	reg_idx_t            cfg_idx;
	logic [CFG_BITS-1:0] wr_size;
	logic [COL_W-1:0]    cols_wr;
	logic [ROW_W-1:0]    rows_wr;
	logic [COL_W-1:0]    cols_q;
	logic [ROW_W-1:0]    rows_q;

	// sweep position
	logic             accept;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	logic             col_end;
	logic             row_end;
	logic             sweep_end;
	logic             has_res;

	// line stores and window
	logic [COL_W-1:0]               up_raddr;
	logic [VALUE_BITS-1:0]          up_rdata;
	logic [VALUE_BITS-1:0]          mid_rdata;
	logic signed [VALUE_BITS-1:0]   north;
	logic signed [VALUE_BITS-1:0]   east;
	logic signed [VALUE_BITS-1:0]   w0_q;
	logic signed [VALUE_BITS-1:0]   w1_q;
	logic signed [VALUE_BITS-1:0]   w2_q;

	// pipeline
	logic signed [SUM_W-1:0]      sum_d;
	logic signed [SUM_W-1:0]      sum_s1;
	logic signed [VALUE_BITS-1:0] half_s1;
	logic                         fin_s1;
	logic                         v_s1_q;
	logic signed [VALUE_BITS-1:0] nv_d;
	logic signed [VALUE_BITS-1:0] nv_s2;
	logic                         fin_s2;
	logic                         v_s2_q;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic signed [ACC_BITS-1:0]   acc_sum;

	// result queue
	logic [RES_W-1:0] push_data;
	logic [RES_W-1:0] out_data;
	logic [OCC_W-1:0] fifo_cnt;
	logic [OCC_W-1:0] inflight;
	logic             out_pop;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign wr_size = pwdata[CFG_BITS-1:0];

	always_comb begin
		if (wr_size == '0) begin
			cols_wr = COL_W'(1);
			rows_wr = ROW_W'(1);
		end else begin
			cols_wr = (wr_size > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(wr_size);
			rows_wr = (wr_size > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(wr_size);
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COLS: prdata = 32'(cols_q);
			REG_ROWS: prdata = 32'(rows_q);
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COL_W'(COLS_RST);
			rows_q <= ROW_W'(ROWS_RST);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COLS: cols_q <= cols_wr;
				REG_ROWS: rows_q <= rows_wr;
				default:  ;
			endcase
		end
	end

	// ------------------------------------------------------------- counters
	assign accept    = cell_valid & cell_ready;
	assign last_col  = cols_q + COL_W'(1);
	assign last_row  = rows_q + ROW_W'(1);
	assign col_end   = col_q == last_col;
	assign row_end   = row_q == last_row;
	assign sweep_end = accept & col_end & row_end;
	assign has_res   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	always_comb begin
		col_nxt = col_q;
		row_nxt = row_q;
		if (cfg_wr) begin
			col_nxt = '0;
			row_nxt = '0;
		end else if (accept) begin
			if (col_end) begin
				col_nxt = '0;
				row_nxt = row_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_nxt = col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// ---------------------------------------------------------- line stores
	// Reads are issued for the next column, so data is ready when its beat
	// arrives; writes never hit the address being prefetched.
	assign up_raddr = (col_nxt == '0) ? '0 : col_nxt - COL_W'(1);

	hss_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (accept && (col_q != '0)),
		.waddr (col_q - COL_W'(1)),
		.wdata (w1_q),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	hss_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (cell_value),
		.raddr (col_nxt),
		.rdata (mid_rdata)
	);

	assign north = up_rdata;
	assign east  = mid_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
		end else if (cfg_wr || sweep_end) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
		end else if (accept) begin
			w0_q <= w1_q;
			w1_q <= east;
			w2_q <= cell_value;
		end
	end

	// ------------------------------------------------------------- pipeline
	assign sum_d = SUM_W'(north) + SUM_W'(w2_q) + SUM_W'(w0_q) + SUM_W'(east);

	always_ff @(posedge clk) begin
		sum_s1  <= sum_d;
		half_s1 <= w1_q >>> 1;
		fin_s1  <= col_end & row_end;
	end

	assign nv_d = VALUE_BITS'(SUM_W'(half_s1) + (sum_s1 >>> 3));

	always_ff @(posedge clk) begin
		nv_s2  <= nv_d;
		fin_s2 <= fin_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= accept & has_res;
			v_s2_q <= v_s1_q;
		end
	end

	assign acc_sum = acc_q + ACC_BITS'(nv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cfg_wr) begin
			acc_q <= '0;
		end else if (v_s2_q) begin
			acc_q <= fin_s2 ? '0 : acc_sum;
		end
	end

	// --------------------------------------------------------- result queue
	assign push_data = {nv_s2, (fin_s2 ? acc_sum : ACC_BITS'(0)), fin_s2};
	assign out_pop   = result_valid & result_ready;

	hss_out_fifo #(
		.WIDTH (RES_W)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2_q),
		.push_data (push_data),
		.pop       (out_pop),
		.valid     (result_valid),
		.data      (out_data),
		.count     (fifo_cnt)
	);

	assign new_value = out_data[RES_W-1 -: VALUE_BITS];
	assign heat_sum  = out_data[ACC_BITS:1];
	assign last      = out_data[0];

	// every result already in the pipe has a queue slot reserved
	assign inflight   = OCC_W'(v_s1_q) + OCC_W'(v_s2_q) + fifo_cnt;
	assign cell_ready = inflight < OCC_W'(OUT_DEPTH);

	// ----------------------------------------------------------- assertions
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q |-> (fifo_cnt < OCC_W'(OUT_DEPTH)))
		else $error("result queue push while full");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight <= OCC_W'(OUT_DEPTH))
		else $error("more results in flight than queue slots");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col) && (row_q <= last_row))
		else $error("sweep position beyond grid");

	a_sweep_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_end |=> (col_q == '0) && (row_q == '0) && (w1_q == '0))
		else $error("sweep did not restart after final cell");

endmodule
`default_nettype wire
